[design/bcrt_pkg.sv]
`default_nettype none

package bcrt_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // Rotation terms are Q2.30; matrix entries are carried on 36 bits.
    localparam int  ROT_FRAC = 30;
    localparam int  MAT_W    = 36;
    localparam logic signed [MAT_W-1:0] MAT_ONE = MAT_W'(64'sd1 <<< ROT_FRAC);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ROT_W    = 3'd0,
        CFG_ROT_X    = 3'd1,
        CFG_ROT_Y    = 3'd2,
        CFG_ROT_Z    = 3'd3,
        CFG_SHIFT_X  = 3'd4,
        CFG_SHIFT_Y  = 3'd5,
        CFG_SHIFT_Z  = 3'd6,
        CFG_BOX_HALF = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic signed [31:0] rot_w;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
        logic        [30:0] box_half_size;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] pt_x;
        logic signed [31:0] pt_y;
        logic signed [31:0] pt_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               in_box;
    } t_out_item;

    // Item as classified by the front end.
    typedef struct packed {
        t_in_item pt;
        logic     in_box;
    } t_mid_item;

endpackage

`default_nettype wire

[design/bcrt_front.sv]
`default_nettype none

module bcrt_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire bcrt_pkg::t_in_item                 i_pt,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [bcrt_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [bcrt_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    input  wire logic                               i_q_full,
    output logic                                    o_q_wr,
    output bcrt_pkg::t_mid_item                     o_q_item,
    output bcrt_pkg::t_cfg                          o_cfg
);

    bcrt_pkg::t_cfg r_cfg;
    logic [31:0]    mag_x, mag_y, mag_z;
    logic [31:0]    half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_w         <= 32'sh4000_0000;
            r_cfg.rot_x         <= '0;
            r_cfg.rot_y         <= '0;
            r_cfg.rot_z         <= '0;
            r_cfg.shift_x       <= '0;
            r_cfg.shift_y       <= '0;
            r_cfg.shift_z       <= '0;
            r_cfg.box_half_size <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (bcrt_pkg::t_cfg_reg'(i_cfg_addr))
                bcrt_pkg::CFG_ROT_W:    r_cfg.rot_w         <= i_cfg_wr_data;
                bcrt_pkg::CFG_ROT_X:    r_cfg.rot_x         <= i_cfg_wr_data;
                bcrt_pkg::CFG_ROT_Y:    r_cfg.rot_y         <= i_cfg_wr_data;
                bcrt_pkg::CFG_ROT_Z:    r_cfg.rot_z         <= i_cfg_wr_data;
                bcrt_pkg::CFG_SHIFT_X:  r_cfg.shift_x       <= i_cfg_wr_data;
                bcrt_pkg::CFG_SHIFT_Y:  r_cfg.shift_y       <= i_cfg_wr_data;
                bcrt_pkg::CFG_SHIFT_Z:  r_cfg.shift_z       <= i_cfg_wr_data;
                bcrt_pkg::CFG_BOX_HALF: r_cfg.box_half_size <= i_cfg_wr_data[30:0];
                default: ;
            endcase
        end
    end

    // Magnitudes as unsigned 32 bit; the most negative value maps to 2^31.
    assign mag_x = i_pt.pt_x[31] ? (~i_pt.pt_x + 32'd1) : i_pt.pt_x;
    assign mag_y = i_pt.pt_y[31] ? (~i_pt.pt_y + 32'd1) : i_pt.pt_y;
    assign mag_z = i_pt.pt_z[31] ? (~i_pt.pt_z + 32'd1) : i_pt.pt_z;
    assign half  = {1'b0, r_cfg.box_half_size};

    assign full            = i_q_full;
    assign o_q_wr          = push && !i_q_full;
    assign o_q_item.pt     = i_pt;
    assign o_q_item.in_box = (mag_x < half) && (mag_y < half) && (mag_z < half);
    assign o_cfg           = r_cfg;

endmodule

`default_nettype wire

[design/bcrt_queue.sv]
`default_nettype none

module bcrt_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire bcrt_pkg::t_mid_item  i_wr_item,
    output logic                      o_full,
    input  wire logic                 i_rd,
    output bcrt_pkg::t_mid_item       o_rd_item,
    output logic                      o_empty
);

    bcrt_pkg::t_mid_item                 r_mem [bcrt_pkg::Q_DEPTH];
    logic [bcrt_pkg::Q_PTR_W-1:0]        r_wr_ptr, r_rd_ptr;
    logic [bcrt_pkg::Q_CNT_W-1:0]        r_cnt;
    logic                                do_wr, do_rd;

    assign o_full  = (r_cnt == bcrt_pkg::Q_CNT_W'(bcrt_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    assign o_rd_item = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

[design/bcrt_back.sv]
`default_nettype none

module bcrt_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bcrt_pkg::t_cfg       i_cfg,
    input  wire logic                 i_q_empty,
    input  wire bcrt_pkg::t_mid_item  i_q_item,
    output logic                      o_q_rd,
    output logic                      empty,
    input  wire logic                 pop,
    output bcrt_pkg::t_out_item       o_res
);

    localparam int MW = bcrt_pkg::MAT_W;

    logic adv;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1: quaternion products
    logic signed [63:0]  r1_qp [9];
    bcrt_pkg::t_mid_item r1_item;
    // stage 2: matrix entries
    logic signed [MW-1:0] r2_m [9];
    bcrt_pkg::t_mid_item  r2_item;
    // stage 3: entry times high / low half of coordinate
    logic signed [MW+15:0] r3_a [9];
    logic signed [MW+16:0] r3_b [9];
    logic                  r3_in;
    // stage 4: floored products
    logic signed [38:0] r4_t [9];
    logic               r4_in;
    // stage 5: result
    bcrt_pkg::t_out_item r5_res;

    logic signed [34:0]    q [9];
    logic signed [MW-1:0]  n_m [9];
    logic signed [31:0]    p2 [3];
    logic signed [38:0]    n_t [9];
    logic signed [40:0]    sum [3];
    logic signed [31:0]    shv [3];
    logic signed [31:0]    sat [3];

    assign adv    = !r_v5 || pop;
    assign o_q_rd = adv && !i_q_empty;
    assign empty  = !r_v5;
    assign o_res  = r5_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= !i_q_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // order: wx wy wz xx xy xz yy yz zz
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_qp[0] <= i_cfg.rot_x * i_cfg.rot_w;
            r1_qp[1] <= i_cfg.rot_y * i_cfg.rot_w;
            r1_qp[2] <= i_cfg.rot_z * i_cfg.rot_w;
            r1_qp[3] <= i_cfg.rot_x * i_cfg.rot_x;
            r1_qp[4] <= i_cfg.rot_y * i_cfg.rot_x;
            r1_qp[5] <= i_cfg.rot_z * i_cfg.rot_x;
            r1_qp[6] <= i_cfg.rot_y * i_cfg.rot_y;
            r1_qp[7] <= i_cfg.rot_z * i_cfg.rot_y;
            r1_qp[8] <= i_cfg.rot_z * i_cfg.rot_z;
            r1_item  <= i_q_item;
        end
    end

    // doubled products, floored to Q.30
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            q[k] = r1_qp[k][63:29];
        end
        n_m[0] = bcrt_pkg::MAT_ONE - (MW'(q[6]) + MW'(q[8]));
        n_m[1] = MW'(q[4]) - MW'(q[2]);
        n_m[2] = MW'(q[5]) + MW'(q[1]);
        n_m[3] = MW'(q[4]) + MW'(q[2]);
        n_m[4] = bcrt_pkg::MAT_ONE - (MW'(q[3]) + MW'(q[8]));
        n_m[5] = MW'(q[7]) - MW'(q[0]);
        n_m[6] = MW'(q[5]) - MW'(q[1]);
        n_m[7] = MW'(q[7]) + MW'(q[0]);
        n_m[8] = bcrt_pkg::MAT_ONE - (MW'(q[3]) + MW'(q[6]));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                r2_m[k] <= n_m[k];
            end
            r2_item <= r1_item;
        end
    end

    assign p2[0] = r2_item.pt.pt_x;
    assign p2[1] = r2_item.pt.pt_y;
    assign p2[2] = r2_item.pt.pt_z;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                r3_a[k] <= r2_m[k] * $signed(p2[k % 3][31:16]);
                r3_b[k] <= r2_m[k] * $signed({1'b0, p2[k % 3][15:0]});
            end
            r3_in <= r2_item.in_box;
        end
    end

    // floor((a * 2^16 + b) / 2^30)
    always_comb begin
        logic signed [MW+32:0] full_p;
        for (int k = 0; k < 9; k++) begin
            full_p = ((MW+33)'(r3_a[k]) <<< 16) + (MW+33)'(r3_b[k]);
            n_t[k] = full_p[MW+32:bcrt_pkg::ROT_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                r4_t[k] <= n_t[k];
            end
            r4_in <= r3_in;
        end
    end

    assign shv[0] = i_cfg.shift_x;
    assign shv[1] = i_cfg.shift_y;
    assign shv[2] = i_cfg.shift_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum[r] = 41'(r4_t[3*r]) + 41'(r4_t[3*r+1]) + 41'(r4_t[3*r+2]) + 41'(shv[r]);
            if (sum[r][40:31] != {10{sum[r][40]}}) begin
                sat[r] = sum[r][40] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                sat[r] = sum[r][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_res.out_x  <= sat[0];
            r5_res.out_y  <= sat[1];
            r5_res.out_z  <= sat[2];
            r5_res.in_box <= r4_in;
        end
    end

endmodule

`default_nettype wire

[design/box_cull_rigid_transform.sv]
// Channel   | Handshake            | Payload                        | Direction
// ----------+----------------------+--------------------------------+----------
// points    | push / full          | i_pt  (pt_x, pt_y, pt_z)       | in
// results   | pop / empty          | o_res (out_x..z, in_box)       | out
// config    | i_cfg_wr_en          | i_cfg_addr, i_cfg_wr_data      | in
//
// One item per cycle sustained unless the result output stalls. A result
// passes the input queue and the back-end registers (quaternion products,
// matrix, split coordinate products, floor); sum and saturate load o_res.
// Synchronous reset: identity rotation, no shift, box half-size zero, all empty.
// A stalled result output holds the whole back end; the 4-entry queue keeps
// taking points until it fills, then full rises.
`default_nettype none

module box_cull_rigid_transform (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // point input
    input  wire logic                               push,
    output logic                                    full,
    input  wire bcrt_pkg::t_in_item                 i_pt,
    // result output
    output logic                                    empty,
    input  wire logic                               pop,
    output bcrt_pkg::t_out_item                     o_res,
    // config writes, only while no item is in flight
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [bcrt_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [bcrt_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data
);

    bcrt_pkg::t_cfg       cfg;
    logic                 q_wr;
    bcrt_pkg::t_mid_item  q_wr_item;
    bcrt_pkg::t_mid_item  q_rd_item;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_rd;

    // Front end: config registers, input handshake, box classification.
    bcrt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_pt          (i_pt),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr),
        .o_q_item      (q_wr_item),
        .o_cfg         (cfg)
    );

    // Decouples the front end from back-end stalls.
    bcrt_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_item (q_wr_item),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_rd_item (q_rd_item),
        .o_empty   (q_empty)
    );

    // Back end: rotate, translate, saturate.
    bcrt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_q_item  (q_rd_item),
        .o_q_rd    (q_rd),
        .empty     (empty),
        .pop       (pop),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

[design/bcrt_checker.sv]
`default_nettype none

module bcrt_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    input  wire logic                 full,
    input  wire logic                 empty,
    input  wire logic                 pop,
    input  wire bcrt_pkg::t_out_item  o_res
);

    logic [3:0] r_cnt;
    logic       in_acc, out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    // items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 4'(in_acc) - 4'(out_acc);
        end
    end

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty) else $error("result shown right after reset");

    a_no_result_without_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_cnt != 4'd0)) else $error("result with no item in flight");

    a_not_full_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 4'd0) |-> !full) else $error("full with nothing in flight");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_cnt == 4'd0) |=> empty) else $error("result too early");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res))) else $error("stalled result moved");

endmodule

bind box_cull_rigid_transform bcrt_checker u_bcrt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_res   (o_res)
);

`default_nettype wire
